FILE: rtl/sajk_pkg.sv
package sajk_pkg;

  localparam int SAMPLE_BITS = 11;
  localparam int SLOT_W = 5;
  localparam int CMD_SLOTS = 4;

  // Event codes carried on the result stream's user lane.
  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_KEY  = 2'd1,
    EV_SYNC = 2'd2
  } ev_kind_t;

  // Configuration register indexes.
  localparam logic REG_LOW_THR  = 1'b0;
  localparam logic REG_HIGH_THR = 1'b1;

  localparam logic [SAMPLE_BITS-1:0] LOW_THR_RST  = 11'd900;
  localparam logic [SAMPLE_BITS-1:0] HIGH_THR_RST = 11'd1148;

  // Converter command per channel, sent MSB first.
  localparam logic [3:0] CHAN_CMD [4] = '{4'd12, 4'd14, 4'd13, 4'd15};

  typedef struct packed {
    logic sel;
    logic clk;
    logic mosi;
  } slot_io_t;

  typedef struct packed {
    ev_kind_t   kind;
    logic [2:0] key;
    logic       pressed;
  } key_ev_t;

  // Everything one bit slot produces: pin levels shared by all its words,
  // the number of words (1 to 3) and the words' event parts.
  typedef struct packed {
    slot_io_t          io;
    logic [1:0]        cnt;
    key_ev_t [2:0]     ev;
  } res_set_t;

endpackage

FILE: rtl/spi_adc_joystick_key_scanner_core.sv
// Joystick key scanner: drives a bit-serial converter through four axes and
// turns each reading into key press and release events.
// Input stream: each accepted word (in_tdata bit 0 = serial data line level)
// is one bit slot of a frame of 5 + SAMPLE_CLOCKS slots.
// Result stream: each slot gives one to three words. out_tdata carries the
// pin levels for the slot plus the key fields, out_tuser the event kind
// (none, key, sync) and out_tlast marks the final word of the slot.
// Configuration: cfg_we writes cfg_wdata into the low (index 0) or high
// (index 1) threshold; write only while the block is idle.
// The first word of a slot is valid in the cycle after acceptance.
// Throughput: one slot per cycle while slots give a single word and the
// receiver takes them; a frame-end slot with several events holds the input
// until the single output word register has serialized its extra words.
// Reset (rst_n low, synchronous) returns to slot 0 of channel 0 with all keys
// released and thresholds 900 and 1148, and empties the output register.
// When the receiver stalls, the output word holds and the input is refused
// once the held slot's final word cannot leave.
module spi_adc_joystick_key_scanner_core #(
  parameter int SAMPLE_CLOCKS = 12
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic                              cfg_addr,
  input  logic [sajk_pkg::SAMPLE_BITS-1:0]  cfg_wdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,   // [0] miso_bit, [7:1] zero
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [0] select_level, [1] clock_pulse, [2] mosi_level, [5:3] key_index,
  // [6] key_pressed, [7] zero
  output logic [7:0]                        out_tdata,
  output logic [1:0]                        out_tuser,  // [1:0] event_kind
  output logic                              out_tlast
);

  logic               in_fire;
  sajk_pkg::res_set_t res;

  assign in_fire = in_tvalid && in_tready;

  sajk_slot_engine #(
    .SAMPLE_CLOCKS(SAMPLE_CLOCKS)
  ) u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .in_fire  (in_fire),
    .miso     (in_tdata[0]),
    .res      (res)
  );

  sajk_out_buf u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_fire),
    .res       (res),
    .can_load  (in_tready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

endmodule

FILE: rtl/sajk_slot_engine.sv
module sajk_slot_engine #(
  parameter int SAMPLE_CLOCKS = 12
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic                              cfg_addr,
  input  logic [sajk_pkg::SAMPLE_BITS-1:0]  cfg_wdata,
  input  logic                              in_fire,
  input  logic                              miso,
  output sajk_pkg::res_set_t                res
);

  localparam int FRAME_SLOTS = 5 + SAMPLE_CLOCKS;
  localparam logic [sajk_pkg::SLOT_W-1:0] FRAME_LEN = sajk_pkg::SLOT_W'(FRAME_SLOTS);
  localparam logic [sajk_pkg::SLOT_W-1:0] LAST_SLOT = sajk_pkg::SLOT_W'(FRAME_SLOTS - 1);
  localparam logic [sajk_pkg::SLOT_W-1:0] SAMPLE_FIRST =
    sajk_pkg::SLOT_W'(sajk_pkg::CMD_SLOTS + 1);
  localparam logic [sajk_pkg::SLOT_W-1:0] SAMPLE_END =
    sajk_pkg::SLOT_W'(sajk_pkg::CMD_SLOTS + 1 + sajk_pkg::SAMPLE_BITS);

  logic [sajk_pkg::SAMPLE_BITS-1:0] low_thr_r, high_thr_r;
  logic [sajk_pkg::SLOT_W-1:0]      slot_count_r, slot_count_nxt;
  logic [1:0]                       channel_r, channel_nxt;
  logic [sajk_pkg::SAMPLE_BITS-1:0] shift_r, shift_nxt;
  logic [7:0]                       key_flags_r, key_flags_nxt;
  logic                             sync_pend_r, sync_pend_nxt;

  logic [sajk_pkg::SLOT_W-1:0] slot;
  logic [1:0]                  cmd_bit;
  logic [3:0]                  cmd;
  logic                        frame_end;
  logic                        lo_now, hi_now, lo_chg, hi_chg, sync_ev;
  logic [2:0]                  lo_key, hi_key;
  sajk_pkg::key_ev_t           ev_lo, ev_hi, ev_sync, ev_none;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_thr_r  <= sajk_pkg::LOW_THR_RST;
      high_thr_r <= sajk_pkg::HIGH_THR_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        sajk_pkg::REG_LOW_THR:  low_thr_r  <= cfg_wdata;
        sajk_pkg::REG_HIGH_THR: high_thr_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    slot      = (slot_count_r >= FRAME_LEN) ? '0 : slot_count_r;
    cmd       = sajk_pkg::CHAN_CMD[channel_r];
    cmd_bit   = 2'(sajk_pkg::SLOT_W'(sajk_pkg::CMD_SLOTS) - slot);
    frame_end = (slot == LAST_SLOT);

    res.io.sel  = (slot == '0);
    res.io.clk  = (slot != '0);
    res.io.mosi = (slot != '0) && (slot <= sajk_pkg::SLOT_W'(sajk_pkg::CMD_SLOTS)) &&
                  cmd[cmd_bit];

    shift_nxt = shift_r;
    if (slot == '0) begin
      shift_nxt = '0;
    end else if (slot >= SAMPLE_FIRST && slot < SAMPLE_END) begin
      shift_nxt = {shift_r[sajk_pkg::SAMPLE_BITS-2:0], miso};
    end

    // The comparison sees the sample including this slot's bit.
    lo_key = {channel_r, 1'b0};
    hi_key = {channel_r, 1'b1};
    lo_now = shift_nxt < low_thr_r;
    hi_now = shift_nxt > high_thr_r;
    lo_chg = frame_end && (lo_now != key_flags_r[lo_key]);
    hi_chg = frame_end && (hi_now != key_flags_r[hi_key]);
    sync_ev = frame_end && (channel_r == 2'd3) && (sync_pend_r || lo_chg || hi_chg);

    key_flags_nxt = key_flags_r;
    sync_pend_nxt = sync_pend_r;
    channel_nxt   = channel_r;
    slot_count_nxt = slot + sajk_pkg::SLOT_W'(1);
    if (frame_end) begin
      key_flags_nxt[lo_key] = lo_now;
      key_flags_nxt[hi_key] = hi_now;
      sync_pend_nxt = (channel_r == 2'd3) ? 1'b0 : (sync_pend_r || lo_chg || hi_chg);
      channel_nxt   = channel_r + 2'd1;
      slot_count_nxt = '0;
    end

    ev_none = '{kind: sajk_pkg::EV_NONE, key: 3'd0, pressed: 1'b0};
    ev_lo   = '{kind: sajk_pkg::EV_KEY, key: lo_key, pressed: lo_now};
    ev_hi   = '{kind: sajk_pkg::EV_KEY, key: hi_key, pressed: hi_now};
    ev_sync = '{kind: sajk_pkg::EV_SYNC, key: 3'd0, pressed: 1'b0};

    // Pack the events in order: low key, high key, sync.
    res.ev[0] = lo_chg ? ev_lo : hi_chg ? ev_hi : sync_ev ? ev_sync : ev_none;
    res.ev[1] = (lo_chg && hi_chg) ? ev_hi :
                ((lo_chg ^ hi_chg) && sync_ev) ? ev_sync : ev_none;
    res.ev[2] = (lo_chg && hi_chg && sync_ev) ? ev_sync : ev_none;
    res.cnt   = 2'({1'b0, lo_chg} + {1'b0, hi_chg} + {1'b0, sync_ev});
    if (res.cnt == 2'd0) begin
      res.cnt = 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_count_r <= '0;
      channel_r    <= '0;
      shift_r      <= '0;
      key_flags_r  <= '0;
      sync_pend_r  <= 1'b0;
    end else if (in_fire) begin
      slot_count_r <= slot_count_nxt;
      channel_r    <= channel_nxt;
      shift_r      <= shift_nxt;
      key_flags_r  <= key_flags_nxt;
      sync_pend_r  <= sync_pend_nxt;
    end
  end

endmodule

FILE: rtl/sajk_out_buf.sv
module sajk_out_buf (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  sajk_pkg::res_set_t res,
  output logic               can_load,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [7:0]         out_tdata,
  output logic [1:0]         out_tuser,
  output logic               out_tlast
);

  logic               valid_r;
  logic [1:0]         idx_r;
  sajk_pkg::res_set_t set_r;
  sajk_pkg::key_ev_t  cur;
  logic               take_last;

  assign cur        = set_r.ev[idx_r];
  assign out_tvalid = valid_r;
  assign out_tlast  = (idx_r == set_r.cnt - 2'd1);
  assign out_tuser  = cur.kind;
  assign out_tdata  = {1'b0, cur.pressed, cur.key, set_r.io.mosi, set_r.io.clk, set_r.io.sel};
  assign take_last  = valid_r && out_tready && out_tlast;
  // A new slot's words may enter as the final word of the previous one leaves.
  assign can_load   = !valid_r || take_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else if (load) begin
      valid_r <= 1'b1;
      idx_r   <= '0;
    end else if (take_last) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else if (valid_r && out_tready) begin
      idx_r <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      set_r <= res;
    end
  end

`ifndef SYNTHESIS
  a_cnt_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> set_r.cnt != 2'd0)
    else $error("word buffer holds an empty set");

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> idx_r < set_r.cnt)
    else $error("word index past the end of the set");

  a_sync_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && out_tuser == sajk_pkg::EV_SYNC |-> out_tlast)
    else $error("sync word is not the final word of its slot");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load && valid_r |-> out_tready && out_tlast)
    else $error("set overwritten before its final word was taken");
`endif

endmodule

FILE: verif/tb_top.sv
module tb_top;

  localparam int SAMPLE_CLOCKS = 12;
  localparam int FRAME_LEN = 5 + SAMPLE_CLOCKS;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 80;
  localparam logic [3:0] AXIS_CMD [4] = '{4'd12, 4'd14, 4'd13, 4'd15};

  typedef struct packed {
    logic                 sel;
    logic                 sck;
    logic                 mosi;
    sajk_pkg::ev_kind_t   kind;
    logic [2:0]           key;
    logic                 pressed;
    logic                 last;
  } scan_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_addr = sajk_pkg::REG_LOW_THR;
  logic [10:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // [0] miso_bit, [7:1] zero
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;      // [0] select, [1] clock, [2] mosi, [5:3] key, [6] pressed
  logic [1:0]  out_tuser;      // [1:0] event kind
  logic        out_tlast;

  spi_adc_joystick_key_scanner_core #(.SAMPLE_CLOCKS(SAMPLE_CLOCKS)) dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bit         miso_q[$];
  scan_word_t expected_words[$];
  int         errors = 0;
  int         cycles = 0;
  bit         steady = 1'b0;
  bit         hold_armed = 1'b0;
  bit         hold_used = 1'b0;
  int         hold_left = 0;
  int         in_gap = 0;
  int         out_stall = 0;
  logic       in_fire = 1'b0;

  // Scanner state mirrored by the checker.
  logic [10:0] thr_low, thr_high;
  logic [4:0]  slot_q;
  logic [1:0]  chan_q;
  logic [11:0] shift_q;
  logic [7:0]  keys_q;
  logic        sync_q;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic logic [10:0] pick_sample(int lo, int hi);
    int v;
    case ($urandom_range(0, 5))
      0: v = 0;
      1: v = 2047;
      2: v = lo + $urandom_range(0, 2) - 1;
      3: v = hi + $urandom_range(0, 2) - 1;
      default: v = $urandom_range(0, 2047);
    endcase
    if (v < 0) v = 0;
    if (v > 2047) v = 2047;
    return v[10:0];
  endfunction

  // One frame: header slots with junk on the data line, the sample MSB first,
  // then the surplus clocked bits that the scanner drops.
  task automatic push_frame(input logic [10:0] sample);
    for (int i = 0; i < 5; i++) miso_q.push_back($urandom_range(0, 1));
    for (int i = 10; i >= 0; i--) miso_q.push_back(sample[i]);
    for (int i = 11; i < SAMPLE_CLOCKS; i++) miso_q.push_back($urandom_range(0, 1));
  endtask

  task automatic scan_slot(input logic miso);
    scan_word_t w[3];
    scan_word_t pins;
    int         n;
    int         slot;
    logic [2:0] lo_key, hi_key;
    logic       lo_now, hi_now;
    n = 0;
    pins = '0;
    pins.kind = sajk_pkg::EV_NONE;
    slot = (slot_q >= FRAME_LEN) ? 0 : slot_q;
    if (slot == 0) begin
      pins.sel = 1'b1;
      shift_q = '0;
    end else if (slot <= 4) begin
      pins.sck = 1'b1;
      pins.mosi = AXIS_CMD[chan_q][4 - slot];
    end else begin
      pins.sck = 1'b1;
      if (slot - 5 < 11) shift_q = {shift_q[10:0], miso};
    end
    if (slot == FRAME_LEN - 1) begin
      lo_key = {chan_q, 1'b0};
      hi_key = {chan_q, 1'b1};
      lo_now = shift_q[10:0] < thr_low;
      hi_now = shift_q[10:0] > thr_high;
      if (lo_now != keys_q[lo_key]) begin
        w[n] = pins; w[n].kind = sajk_pkg::EV_KEY; w[n].key = lo_key; w[n].pressed = lo_now;
        n++;
        keys_q[lo_key] = lo_now;
        sync_q = 1'b1;
      end
      if (hi_now != keys_q[hi_key]) begin
        w[n] = pins; w[n].kind = sajk_pkg::EV_KEY; w[n].key = hi_key; w[n].pressed = hi_now;
        n++;
        keys_q[hi_key] = hi_now;
        sync_q = 1'b1;
      end
      if (chan_q == 2'd3) begin
        if (sync_q) begin
          w[n] = pins; w[n].kind = sajk_pkg::EV_SYNC;
          n++;
        end
        sync_q = 1'b0;
      end
      chan_q = chan_q + 2'd1;
      slot_q = '0;
    end else begin
      slot_q = 5'(slot + 1);
    end
    if (n == 0) begin
      w[0] = pins;
      n = 1;
    end
    w[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) expected_words.push_back(w[i]);
  endtask

  task automatic report(input string what, input scan_word_t e, input scan_word_t a);
    errors++;
    if (errors <= 10)
      $display({"%s: expected sel=%0b sck=%0b mosi=%0b kind=%0d key=%0d pr=%0b last=%0b,",
                " got sel=%0b sck=%0b mosi=%0b kind=%0d key=%0d pr=%0b last=%0b"},
               what, e.sel, e.sck, e.mosi, e.kind, e.key, e.pressed, e.last,
               a.sel, a.sck, a.mosi, a.kind, a.key, a.pressed, a.last);
  endtask

  // Sender: holds each word until it is taken, then idles for a random gap.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_fire) begin
      if (in_gap > 0) begin
        in_tvalid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (miso_q.size() > 0) begin
        in_tvalid <= 1'b1;
        in_tdata <= {7'd0, miso_q.pop_front()};
        in_gap <= pick_gap();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // One long receiver hold-off while the sender keeps offering slots.
  always @(negedge clk) begin
    if (hold_armed && !hold_used) begin
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
    end else if (out_stall > 0) begin
      out_tready <= 1'b0;
      out_stall <= out_stall - 1;
    end else begin
      out_tready <= 1'b1;
      out_stall <= pick_gap();
    end
  end

  always @(posedge clk) begin
    scan_word_t got;
    scan_word_t want;
    in_fire <= rst_n && in_tvalid && in_tready;
    if (!rst_n) begin
      thr_low = sajk_pkg::LOW_THR_RST;
      thr_high = sajk_pkg::HIGH_THR_RST;
      slot_q = '0;
      chan_q = '0;
      shift_q = '0;
      keys_q = '0;
      sync_q = 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.sel = out_tdata[0];
        got.sck = out_tdata[1];
        got.mosi = out_tdata[2];
        got.key = out_tdata[5:3];
        got.pressed = out_tdata[6];
        got.kind = sajk_pkg::ev_kind_t'(out_tuser);
        got.last = out_tlast;
        if (expected_words.size() == 0) begin
          report("unexpected word", '0, got);
        end else begin
          want = expected_words.pop_front();
          if (got.sel != want.sel || got.sck != want.sck || got.mosi != want.mosi ||
              got.kind != want.kind || got.key != want.key ||
              got.pressed != want.pressed || got.last != want.last)
            report("mismatch", want, got);
        end
      end
      if (cfg_we) begin
        if (cfg_addr == sajk_pkg::REG_LOW_THR) thr_low = cfg_wdata;
        else thr_high = cfg_wdata;
      end
      if (in_tvalid && in_tready) scan_slot(in_tdata[0]);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic write_reg(input logic addr, input logic [10:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (miso_q.size() != 0 || in_tvalid || expected_words.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    int lo, hi;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset thresholds: a full-scale frame first, then random frames.
    lo = 900;
    hi = 1148;
    push_frame(11'h7FF);
    for (int f = 0; f < 5; f++) push_frame(pick_sample(lo, hi));
    drain();

    // Extremes: neither key can be pressed, so held keys get released.
    lo = 0;
    hi = 2047;
    write_reg(sajk_pkg::REG_LOW_THR, lo[10:0]);
    write_reg(sajk_pkg::REG_HIGH_THR, hi[10:0]);
    hold_armed = 1'b1;
    for (int f = 0; f < 5; f++) push_frame(pick_sample(lo, hi));
    drain();

    // Crossed thresholds: both keys of an axis may be down together.
    lo = 2047;
    hi = 0;
    write_reg(sajk_pkg::REG_LOW_THR, lo[10:0]);
    write_reg(sajk_pkg::REG_HIGH_THR, hi[10:0]);
    steady = 1'b1;
    for (int f = 0; f < 5; f++) push_frame(pick_sample(lo, hi));
    drain();
    steady = 1'b0;

    lo = $urandom_range(0, 2047);
    hi = $urandom_range(0, 2047);
    write_reg(sajk_pkg::REG_HIGH_THR, hi[10:0]);
    write_reg(sajk_pkg::REG_LOW_THR, lo[10:0]);
    for (int f = 0; f < 6; f++) push_frame(pick_sample(lo, hi));
    drain();
    repeat (4) @(negedge clk);

    if (errors == 0 && expected_words.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: spi_adc_joystick_key_scanner_core.f
rtl/sajk_pkg.sv
rtl/sajk_slot_engine.sv
rtl/sajk_out_buf.sv
rtl/spi_adc_joystick_key_scanner_core.sv
verif/tb_top.sv
